// ----- rtl/core/bspi_pkg.sv -----
// shared types, register indexes and the magnitude test for the pruning indexer
package bspi_pkg;

    localparam int EPOCH_W = 8;

    localparam logic [2:0] CFG_MATRIX_ROWS    = 3'd0;
    localparam logic [2:0] CFG_MATRIX_COLS    = 3'd1;
    localparam logic [2:0] CFG_BLOCK_HEIGHT   = 3'd2;
    localparam logic [2:0] CFG_BLOCK_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_KEEP_THRESHOLD = 3'd4;

    localparam logic [31:0] FP_INF_MAG = 32'h7F80_0000;

    // configuration as the datapath sees it, already clamped to legal ranges
    typedef struct packed {
        logic [15:0] rows;
        logic [12:0] cols;
        logic [8:0]  bh;
        logic [8:0]  bw;
        logic [31:0] thr;
    } t_cfg;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               hit;
    } t_flag_entry;

    function automatic logic bspi_pass(input logic [31:0] elem, input logic [31:0] thr);
        logic [31:0] mag;
        logic [31:0] thr_mag;
        logic        res;
        mag     = {1'b0, elem[30:0]};
        thr_mag = {1'b0, thr[30:0]};
        if (mag > FP_INF_MAG) begin
            res = 1'b0;
        end else if (thr_mag > FP_INF_MAG) begin
            res = 1'b0;
        end else if (thr[31]) begin
            res = 1'b1;
        end else begin
            res = (mag >= thr);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/bspi_cfg_regs.sv -----
// configuration registers with range clamping
module bspi_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output bspi_pkg::t_cfg      o_cfg
);
    import bspi_pkg::*;

    logic [15:0] r_rows;
    logic [12:0] r_cols;
    logic [8:0]  r_bh;
    logic [8:0]  r_bw;
    logic [31:0] r_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 16'd1;
            r_cols <= 13'd1;
            r_bh   <= 9'd1;
            r_bw   <= 9'd1;
            r_thr  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MATRIX_ROWS:    r_rows <= i_cfg_data[15:0];
                CFG_MATRIX_COLS:    r_cols <= i_cfg_data[12:0];
                CFG_BLOCK_HEIGHT:   r_bh   <= i_cfg_data[8:0];
                CFG_BLOCK_WIDTH:    r_bw   <= i_cfg_data[8:0];
                CFG_KEEP_THRESHOLD: r_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.rows = (r_rows == 16'd0) ? 16'd1 : r_rows;
        if (r_cols == 13'd0) begin
            o_cfg.cols = 13'd1;
        end else if (r_cols > 13'd4096) begin
            o_cfg.cols = 13'd4096;
        end else begin
            o_cfg.cols = r_cols;
        end
        if (r_bh == 9'd0) begin
            o_cfg.bh = 9'd1;
        end else if (r_bh > 9'd256) begin
            o_cfg.bh = 9'd256;
        end else begin
            o_cfg.bh = r_bh;
        end
        if (r_bw == 9'd0) begin
            o_cfg.bw = 9'd1;
        end else if (r_bw > 9'd256) begin
            o_cfg.bw = 9'd256;
        end else begin
            o_cfg.bw = r_bw;
        end
        o_cfg.thr = r_thr;
    end

endmodule

// ----- rtl/core/block_sparse_prune_indexer_core.sv -----
// dense-to-block-sparse pruning indexer: position counters, hit flag memory, kept counts
// a block's result passes through the compute stage and then the output register after its last element is accepted
// throughput: one element per cycle while the result side does not stall and no flag sweep runs
// the hit flag memory has one read and one write port; flags age out by a matrix epoch tag
// reset: control state clears, then a sweep zeroes every entry of the flag memory
// the same sweep runs again after every 256 matrices when the epoch tag wraps
module block_sparse_prune_indexer_core #(
    parameter int MAX_BLOCK_COLS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_element_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_block_row,
    output logic [11:0] o_block_col,
    output logic        o_kept,
    output logic [27:0] o_slot,
    output logic [27:0] o_row_pointer,
    output logic [27:0] o_kept_total,
    output logic        o_matrix_done
);
    import bspi_pkg::*;

    localparam int FW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
    localparam logic [FW-1:0] FIDX_LAST = FW'(MAX_BLOCK_COLS - 1);

    t_cfg cfg;

    bspi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // position counters
    logic [15:0] r_row;
    logic [11:0] r_col;
    logic [7:0]  r_rib;
    logic [7:0]  r_cib;
    logic [11:0] r_bcol;
    logic [15:0] r_brow;
    logic [FW-1:0] r_fidx;
    logic [EPOCH_W-1:0] r_epoch;
    logic        r_sweep;
    logic [FW-1:0] r_sweep_idx;

    // compute stage
    logic        r_s1_valid;
    logic [31:0] r_s1_elem;
    logic [FW-1:0] r_s1_fidx;
    logic [EPOCH_W-1:0] r_s1_epoch;
    logic [15:0] r_s1_brow;
    logic [11:0] r_s1_bcol;
    logic        r_s1_blk_end;
    logic        r_s1_last_col;
    logic        r_s1_last_row_blk;
    logic        r_s1_done;
    logic        r_fwd_v;
    logic        r_fwd_hit;
    t_flag_entry r_rd;
    t_flag_entry r_mem [MAX_BLOCK_COLS];
    logic [27:0] r_kc;
    logic [27:0] r_rsc;

    logic adv, accept, sweep_we;
    logic last_col, last_row, last_col_blk, last_row_blk, done, blk_end;
    logic old_hit, hit, n_flag;
    logic [27:0] kc_after;

    assign adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !adv || r_sweep;
    assign accept   = i_in_valid && !o_in_stall;
    assign sweep_we = r_sweep && !r_s1_valid;

    always_comb begin
        last_col     = ({1'b0, r_col} + 13'd1) >= cfg.cols;
        last_row     = ({1'b0, r_row} + 17'd1) >= {1'b0, cfg.rows};
        last_col_blk = last_col || (({1'b0, r_cib} + 9'd1) >= cfg.bw);
        last_row_blk = last_row || (({1'b0, r_rib} + 9'd1) >= cfg.bh);
        done         = last_col && last_row;
        blk_end      = last_col_blk && last_row_blk;
    end

    always_comb begin
        old_hit  = r_fwd_v ? r_fwd_hit : (r_rd.hit && (r_rd.epoch == r_s1_epoch));
        hit      = old_hit || bspi_pass(r_s1_elem, cfg.thr);
        n_flag   = r_s1_blk_end ? 1'b0 : hit;
        kc_after = (r_s1_blk_end && hit) ? (r_kc + 28'd1) : r_kc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_rib       <= '0;
            r_cib       <= '0;
            r_bcol      <= '0;
            r_brow      <= '0;
            r_fidx      <= '0;
            r_epoch     <= '0;
            r_sweep     <= 1'b1;
            r_sweep_idx <= '0;
        end else begin
            if (sweep_we) begin
                if (r_sweep_idx == FIDX_LAST) begin
                    r_sweep     <= 1'b0;
                    r_sweep_idx <= '0;
                end else begin
                    r_sweep_idx <= r_sweep_idx + 1'b1;
                end
            end
            if (accept) begin
                if (done) begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_rib   <= '0;
                    r_cib   <= '0;
                    r_bcol  <= '0;
                    r_brow  <= '0;
                    r_fidx  <= '0;
                    r_epoch <= r_epoch + 1'b1;
                    // tag wraps: stale entries could alias, so clear the store
                    if (&r_epoch) begin
                        r_sweep <= 1'b1;
                    end
                end else if (last_col) begin
                    r_col  <= '0;
                    r_cib  <= '0;
                    r_bcol <= '0;
                    r_fidx <= '0;
                    r_row  <= r_row + 16'd1;
                    if (last_row_blk) begin
                        r_rib  <= '0;
                        r_brow <= r_brow + 16'd1;
                    end else begin
                        r_rib <= r_rib + 8'd1;
                    end
                end else begin
                    r_col <= r_col + 12'd1;
                    if (last_col_blk) begin
                        r_cib  <= '0;
                        r_bcol <= r_bcol + 12'd1;
                        r_fidx <= (r_fidx == FIDX_LAST) ? '0 : r_fidx + 1'b1;
                    end else begin
                        r_cib <= r_cib + 8'd1;
                    end
                end
            end
        end
    end

    // flag store: read at accept, written back from the compute stage or zeroed by the sweep
    always_ff @(posedge i_clk) begin
        if (sweep_we) begin
            r_mem[r_sweep_idx] <= '0;
        end else if (adv && r_s1_valid) begin
            r_mem[r_s1_fidx] <= '{epoch: r_s1_epoch, hit: n_flag};
        end
        if (accept) begin
            r_rd <= r_mem[r_fidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_elem         <= i_element_bits;
            r_s1_fidx         <= r_fidx;
            r_s1_epoch        <= r_epoch;
            r_s1_brow         <= r_brow;
            r_s1_bcol         <= r_bcol;
            r_s1_blk_end      <= blk_end;
            r_s1_last_col     <= last_col;
            r_s1_last_row_blk <= last_row_blk;
            r_s1_done         <= done;
            // write in flight to the same entry is missed by the memory read
            r_fwd_v           <= r_s1_valid && (r_s1_fidx == r_fidx);
            r_fwd_hit         <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kc  <= '0;
            r_rsc <= '0;
        end else if (adv && r_s1_valid) begin
            if (r_s1_done) begin
                r_kc  <= '0;
                r_rsc <= '0;
            end else begin
                r_kc <= kc_after;
                if (r_s1_last_col && r_s1_last_row_blk) begin
                    r_rsc <= kc_after;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_s1_valid && r_s1_blk_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid && r_s1_blk_end) begin
            o_block_row   <= r_s1_brow;
            o_block_col   <= r_s1_bcol;
            o_kept        <= hit;
            o_slot        <= hit ? r_kc : 28'd0;
            o_row_pointer <= r_rsc;
            o_kept_total  <= kc_after;
            o_matrix_done <= r_s1_done;
        end
    end

endmodule

// ----- rtl/core/bspi_checker.sv -----
// port-level checks for the pruning indexer, bound to the top level
module bspi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [31:0] i_element_bits,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_block_row,
    input logic [11:0] o_block_col,
    input logic        o_kept,
    input logic [27:0] o_slot,
    input logic [27:0] o_row_pointer,
    input logic [27:0] o_kept_total,
    input logic        o_matrix_done
);

    // a full stalled result register holds back new requests
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request taken while result blocked");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_kept_total)
            && $stable(o_block_col) && $stable(o_block_row)))
        else $error("stalled result changed");

    a_pruned_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_kept) |-> (o_slot == 28'd0 && o_kept_total >= o_row_pointer
            || o_slot == 28'd0))
        else $error("pruned block has nonzero slot");

    a_kept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kept) |-> (o_kept_total == o_slot + 28'd1))
        else $error("kept total does not follow slot");

endmodule

bind block_sparse_prune_indexer_core bspi_checker u_bspi_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the block sparse pruning indexer core
`timescale 1ns / 1ps

module tb_top;
    import bspi_pkg::*;

    localparam int NUM_FLAGS = 4096;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct packed {
        logic [15:0] block_row;
        logic [11:0] block_col;
        logic        kept;
        logic [27:0] slot;
        logic [27:0] row_pointer;
        logic [27:0] kept_total;
        logic        matrix_done;
    } t_block_decision;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_element_bits;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_block_row;
    logic [11:0] o_block_col;
    logic        o_kept;
    logic [27:0] o_slot;
    logic [27:0] o_row_pointer;
    logic [27:0] o_kept_total;
    logic        o_matrix_done;

    block_sparse_prune_indexer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_element_bits (i_element_bits),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_block_row    (o_block_row),
        .o_block_col    (o_block_col),
        .o_kept         (o_kept),
        .o_slot         (o_slot),
        .o_row_pointer  (o_row_pointer),
        .o_kept_total   (o_kept_total),
        .o_matrix_done  (o_matrix_done)
    );

    // predictor state
    logic [15:0] reg_rows;
    logic [12:0] reg_cols;
    logic [8:0]  reg_bh;
    logic [8:0]  reg_bw;
    logic [31:0] reg_thr;
    bit          hit_flag [NUM_FLAGS];
    logic [15:0] row_cnt;
    logic [11:0] col_cnt;
    logic [7:0]  row_in_blk;
    logic [7:0]  col_in_blk;
    logic [11:0] blk_col_cnt;
    logic [15:0] blk_row_cnt;
    logic [27:0] kept_cnt;
    logic [27:0] row_start_cnt;

    logic [31:0]     element_queue[$];
    t_block_decision pending_blocks[$];
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int unsigned     mismatches;
    int unsigned     cycles;
    int unsigned     elements_sent;
    int unsigned     blocks_checked;
    int unsigned     kept_seen;
    int unsigned     matrices_seen;
    logic            in_taken;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] clamp32(input logic [31:0] v, input logic [31:0] lo,
                                            input logic [31:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic bit magnitude_passes(input logic [31:0] elem, input logic [31:0] thr);
        if ({1'b0, elem[30:0]} > 32'h7F80_0000) begin
            return 1'b0;
        end
        if ({1'b0, thr[30:0]} > 32'h7F80_0000) begin
            return 1'b0;
        end
        if (thr[31]) begin
            return 1'b1;
        end
        return {1'b0, elem[30:0]} >= thr;
    endfunction

    function void clear_indexer();
        foreach (hit_flag[k]) hit_flag[k] = 1'b0;
        row_cnt = '0;
        col_cnt = '0;
        row_in_blk = '0;
        col_in_blk = '0;
        blk_col_cnt = '0;
        blk_row_cnt = '0;
        kept_cnt = '0;
        row_start_cnt = '0;
    endfunction

    // advance the indexer by one element, queue a decision when a block closes
    function void index_element(input logic [31:0] elem);
        logic [31:0]     rows;
        logic [31:0]     cols;
        logic [31:0]     bh;
        logic [31:0]     bw;
        int              fidx;
        bit              last_col;
        bit              last_row;
        bit              last_col_blk;
        bit              last_row_blk;
        bit              done;
        t_block_decision d;
        rows = clamp32({16'd0, reg_rows}, 1, 65535);
        cols = clamp32({19'd0, reg_cols}, 1, 4096);
        bh = clamp32({23'd0, reg_bh}, 1, 256);
        bw = clamp32({23'd0, reg_bw}, 1, 256);
        fidx = blk_col_cnt % NUM_FLAGS;
        last_col = ({20'd0, col_cnt} + 1) >= cols;
        last_row = ({16'd0, row_cnt} + 1) >= rows;
        last_col_blk = last_col || ({24'd0, col_in_blk} + 1) >= bw;
        last_row_blk = last_row || ({24'd0, row_in_blk} + 1) >= bh;
        done = last_col && last_row;
        if (magnitude_passes(elem, reg_thr)) begin
            hit_flag[fidx] = 1'b1;
        end
        if (last_col_blk && last_row_blk) begin
            d.block_row = blk_row_cnt;
            d.block_col = blk_col_cnt;
            d.kept = hit_flag[fidx];
            d.slot = hit_flag[fidx] ? kept_cnt : 28'd0;
            if (hit_flag[fidx]) begin
                kept_cnt = kept_cnt + 28'd1;
            end
            hit_flag[fidx] = 1'b0;
            d.row_pointer = row_start_cnt;
            d.kept_total = kept_cnt;
            d.matrix_done = done;
            pending_blocks.push_back(d);
        end
        if (done) begin
            clear_indexer();
        end else if (last_col) begin
            if (last_row_blk) begin
                row_start_cnt = kept_cnt;
            end
            col_cnt = '0;
            col_in_blk = '0;
            blk_col_cnt = '0;
            row_cnt = row_cnt + 16'd1;
            if (last_row_blk) begin
                row_in_blk = '0;
                blk_row_cnt = blk_row_cnt + 16'd1;
            end else begin
                row_in_blk = row_in_blk + 8'd1;
            end
        end else begin
            col_cnt = col_cnt + 12'd1;
            if (last_col_blk) begin
                col_in_blk = '0;
                blk_col_cnt = blk_col_cnt + 12'd1;
            end else begin
                col_in_blk = col_in_blk + 8'd1;
            end
        end
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (element_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_element_bits <= element_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: predicts on accepted requests, checks accepted results
    always @(posedge i_clk) begin
        t_block_decision want;
        t_block_decision got;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            index_element(i_element_bits);
            elements_sent++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_block_row, o_block_col, o_kept, o_slot, o_row_pointer,
                   o_kept_total, o_matrix_done};
            if (pending_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: row %0d col %0d kept %0b", o_block_row,
                             o_block_col, o_kept);
                end
            end else begin
                want = pending_blocks.pop_front();
                blocks_checked++;
                kept_seen += want.kept;
                matrices_seen += want.matrix_done;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch exp: row %0d col %0d kept %0b slot %0d",
                                  " rp %0d tot %0d done %0b"},
                                 want.block_row, want.block_col, want.kept, want.slot,
                                 want.row_pointer, want.kept_total, want.matrix_done);
                        $display({"         got: row %0d col %0d kept %0b slot %0d",
                                  " rp %0d tot %0d done %0b"},
                                 got.block_row, got.block_col, got.kept, got.slot,
                                 got.row_pointer, got.kept_total, got.matrix_done);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("timeout with %0d results outstanding", pending_blocks.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MATRIX_ROWS:    reg_rows = data[15:0];
            CFG_MATRIX_COLS:    reg_cols = data[12:0];
            CFG_BLOCK_HEIGHT:   reg_bh = data[8:0];
            CFG_BLOCK_WIDTH:    reg_bw = data[8:0];
            CFG_KEEP_THRESHOLD: reg_thr = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every result, then let in-flight non-result elements settle
    task automatic drain();
        wait (element_queue.size() == 0 && !i_in_valid && pending_blocks.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [31:0] rows, input logic [31:0] cols,
                             input logic [31:0] bh, input logic [31:0] bw,
                             input logic [31:0] thr);
        drain();
        write_reg(CFG_MATRIX_ROWS, rows);
        write_reg(CFG_MATRIX_COLS, cols);
        write_reg(CFG_BLOCK_HEIGHT, bh);
        write_reg(CFG_BLOCK_WIDTH, bw);
        write_reg(CFG_KEEP_THRESHOLD, thr);
    endtask

    function automatic logic [31:0] pick_element(input logic [31:0] thr);
        logic [31:0] specials [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                      32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                      32'h7F7F_FFFF, 32'h0000_0001};
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2:       return specials[$urandom_range(7)];
            3:       return {1'($urandom_range(1)),
                             thr[30:0] + 31'($urandom_range(2)) - 31'd1};
            default: return {1'($urandom_range(1)),
                             31'($urandom % ({1'b0, thr[30:0]} + 32'd1))};
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(5))
            0:       return 32'h3F80_0000;
            1:       return $urandom;
            2:       return 32'h7FC0_0001;
            3:       return 32'h8000_0000 | $urandom;
            4:       return 32'h0000_0000;
            default: return 32'h4000_0000 + $urandom_range(32'h0100_0000);
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n) element_queue.push_back(pick_element(reg_thr));
    endtask

    initial begin
        logic [31:0] r_rows;
        logic [31:0] r_cols;
        logic [31:0] r_bh;
        logic [31:0] r_bw;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MATRIX_ROWS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_element_bits = '0;
        i_out_stall = 1'b0;
        in_taken = 1'b0;
        mismatches = 0;
        cycles = 0;
        elements_sent = 0;
        blocks_checked = 0;
        kept_seen = 0;
        matrices_seen = 0;
        send_idle_pct = 8;
        recv_stall_pct = 46;
        reg_rows = 16'd1;
        reg_cols = 13'd1;
        reg_bh = 9'd1;
        reg_bw = 9'd1;
        reg_thr = 32'd0;
        clear_indexer();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // partial edge blocks, threshold exactly 1.0
        set_shape(4, 5, 2, 2, 32'h3F80_0000);
        element_queue = '{32'h3F80_0000, 32'h3F7F_FFFF, 32'hBF80_0000, 32'h7F80_0000,
                          32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                          32'h8000_0000, 32'h7F7F_FFFF, 32'h3F7F_FFFF, 32'h0000_0001,
                          32'hBF7F_FFFF, 32'h7F80_0001, 32'h3F80_0001, 32'h0000_0000,
                          32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
        // nan threshold blocks everything, negative zero threshold passes everything but a nan element
        set_shape(1, 2, 1, 1, 32'h7FC0_0001);
        element_queue = '{32'h7F80_0000, 32'h7F7F_FFFF};
        set_shape(1, 2, 1, 1, 32'h8000_0000);
        element_queue = '{32'h0000_0000, 32'hFFC0_0000};

        // zero and oversize registers clamp
        set_shape(0, 0, 0, 0, 32'hFFFF_FFFF);
        push_random(6);
        set_shape(3, 8191, 511, 300, 32'h3F80_0000);
        push_random(20);
        // largest shape, left mid-matrix and then reshaped
        set_shape(65535, 4096, 256, 256, 32'h7F80_0000);
        push_random(30);
        set_shape(65535, 4096, 1, 1, 32'h3F00_0000);
        push_random(40);

        // random shapes across the three idling regimes
        for (int ph = 0; ph < 15; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 46;
                recv_stall_pct = 8;
            end else if (ph == 10) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            r_rows = $urandom_range(8);
            r_cols = $urandom_range(12);
            r_bh = $urandom_range(4);
            r_bw = $urandom_range(5);
            if (ph == 7) begin
                r_rows = 1;
                r_cols = 1;
                r_bh = 1;
                r_bw = 1;
            end
            set_shape(r_rows, r_cols, r_bh, r_bw, pick_threshold());
            // tiny matrices run the epoch tag through its wrap
            push_random(ph == 7 ? 280 : 22);
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("sent %0d elements, checked %0d block decisions (%0d kept, %0d matrices)",
                 elements_sent, blocks_checked, kept_seen, matrices_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
